[hdl/multi_queue_linked_buffer_manager_defines.svh]
// ----------------------------------------------------------------------------
// Multi-queue linked buffer manager: assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef MULTI_QUEUE_LINKED_BUFFER_MANAGER_DEFINES_SVH
`define MULTI_QUEUE_LINKED_BUFFER_MANAGER_DEFINES_SVH

`define MQLBM_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`define MQLBM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/mqlbm_pkg.sv]
// ----------------------------------------------------------------------------
// Multi-queue linked buffer manager: package
// Request and response types, operation and status codes, shared constants.
// ----------------------------------------------------------------------------
package mqlbm_pkg;

  localparam int unsigned NodeW            = 8;
  localparam int unsigned CountW           = 9;
  localparam int unsigned QueueIdW         = 3;
  localparam int unsigned ActionW          = 2;
  localparam int unsigned StatusW          = 2;
  localparam int unsigned NumQueuesDefault = 8;
  localparam int unsigned PoolDepthDefault = 256;
  localparam logic [CountW-1:0] PoolSizeReset = 9'd256;

  typedef enum logic [ActionW-1:0] {
    ACT_ENQUEUE = 2'd0,
    ACT_DEQUEUE = 2'd1,
    ACT_QUERY   = 2'd2
  } action_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_OUTSIDE = 2'd2,
    ST_QUEUED  = 2'd3
  } status_e;

  typedef struct packed {
    logic [ActionW-1:0]  action;
    logic [QueueIdW-1:0] queue_sel;
    logic [NodeW-1:0]    node_index;
  } req_t;

  typedef struct packed {
    logic [NodeW-1:0]   node_out;
    logic [CountW-1:0]  queue_count;
    logic [StatusW-1:0] status;
  } rsp_t;

  typedef struct packed {
    logic link_we;
    logic flag_we;
    logic flag_data;
  } mem_ctl_t;

endpackage

[hdl/multi_queue_linked_buffer_manager.sv]
// ----------------------------------------------------------------------------
// Multi-queue linked buffer manager
// Flow: a request taken at a clock edge reads the memories into the s1 stage,
// is decided there in one pass and its result is registered with its strobe.
// Throughput: one request per cycle; busy stays low and results cannot stall.
// Reset and pool size writes rebuild all queues: every pool node in the free
// queue, handed out in descending order.
// ----------------------------------------------------------------------------
`include "multi_queue_linked_buffer_manager_defines.svh"

module multi_queue_linked_buffer_manager #(
  parameter int unsigned NUM_QUEUES = mqlbm_pkg::NumQueuesDefault,
  parameter int unsigned POOL_DEPTH = mqlbm_pkg::PoolDepthDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  mqlbm_pkg::req_t             req_i,
  output logic                        result_valid_o,
  output mqlbm_pkg::rsp_t             rsp_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [mqlbm_pkg::CountW-1:0] cfg_data_i
);

  localparam int unsigned NW = $clog2(POOL_DEPTH);
  localparam int unsigned CountW = mqlbm_pkg::CountW;

  logic                accept;
  logic                s1_valid_q;
  mqlbm_pkg::req_t     s1_req_q;
  logic                result_valid_q;
  mqlbm_pkg::rsp_t     rsp_q;
  mqlbm_pkg::rsp_t     rsp_d;
  mqlbm_pkg::mem_ctl_t mem_ctl;
  logic [NW-1:0]       link_addr;
  logic [NW-1:0]       link_data;
  logic [NW-1:0]       flag_addr;
  logic [NW-1:0]       fwd_oldest;
  logic [NW-1:0]       link_rd;
  logic                queued_rd;
  logic [CountW-1:0]   region;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q     <= 1'b0;
      result_valid_q <= 1'b0;
    end else begin
      s1_valid_q     <= accept;
      result_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_req_q <= req_i;
    end
    if (s1_valid_q) begin
      rsp_q <= rsp_d;
    end
  end

  mqlbm_node_store #(
    .POOL_DEPTH (POOL_DEPTH)
  ) u_node_store (
    .clk_i       (clk_i),
    .rd_en_i     (accept),
    .rd_node_i   (NW'(req_i.node_index)),
    .rd_link_i   (fwd_oldest),
    .ctl_i       (mem_ctl),
    .link_addr_i (link_addr),
    .link_data_i (link_data),
    .flag_addr_i (flag_addr),
    .region_i    (region),
    .link_o      (link_rd),
    .queued_o    (queued_rd)
  );

  mqlbm_queue_ctrl #(
    .NUM_QUEUES (NUM_QUEUES),
    .POOL_DEPTH (POOL_DEPTH)
  ) u_queue_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_valid_i && cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .s1_valid_i   (s1_valid_q),
    .s1_req_i     (s1_req_q),
    .in_queue_i   (req_i.queue_sel),
    .link_i       (link_rd),
    .queued_i     (queued_rd),
    .region_o     (region),
    .fwd_oldest_o (fwd_oldest),
    .ctl_o        (mem_ctl),
    .link_addr_o  (link_addr),
    .link_data_o  (link_data),
    .flag_addr_o  (flag_addr),
    .rsp_o        (rsp_d)
  );

  assign result_valid_o = result_valid_q;
  assign rsp_o          = rsp_q;

  `MQLBM_ASSERT_NEXT(a_strobe_follows, s1_valid_q, result_valid_q,
                     "Result strobe missing after a request in flight.")
  `MQLBM_ASSERT_IMPL(a_empty_fields,
                     result_valid_q && (rsp_q.status == mqlbm_pkg::ST_EMPTY),
                     (rsp_q.node_out == '0) && (rsp_q.queue_count == '0),
                     "Empty status with a non-zero node or count.")
  `MQLBM_ASSERT_IMPL(a_node_out_ok, result_valid_q && (rsp_q.node_out != '0),
                     rsp_q.status == mqlbm_pkg::ST_OK,
                     "Node returned with a failing status.")

endmodule

[hdl/mqlbm_node_store.sv]
// ----------------------------------------------------------------------------
// Multi-queue linked buffer manager: node store
// Link and queued-flag memories with registered reads, write bypass and the
// untouched descending region of the free queue.
// ----------------------------------------------------------------------------
module mqlbm_node_store #(
  parameter int unsigned POOL_DEPTH = mqlbm_pkg::PoolDepthDefault,
  localparam int unsigned NW = $clog2(POOL_DEPTH),
  localparam int unsigned CountW = mqlbm_pkg::CountW
) (
  input  logic                clk_i,
  input  logic                rd_en_i,
  input  logic [NW-1:0]       rd_node_i,
  input  logic [NW-1:0]       rd_link_i,
  input  mqlbm_pkg::mem_ctl_t ctl_i,
  input  logic [NW-1:0]       link_addr_i,
  input  logic [NW-1:0]       link_data_i,
  input  logic [NW-1:0]       flag_addr_i,
  input  logic [CountW-1:0]   region_i,
  output logic [NW-1:0]       link_o,
  output logic                queued_o
);

  logic [NW-1:0] link_mem [POOL_DEPTH];
  logic          flag_mem [POOL_DEPTH];

  logic [NW-1:0] link_rd_q;
  logic [NW-1:0] link_addr_q;
  logic          link_byp_q;
  logic [NW-1:0] link_byp_data_q;
  logic          flag_rd_q;
  logic [NW-1:0] node_addr_q;
  logic          flag_byp_q;
  logic          flag_byp_data_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.link_we) begin
      link_mem[link_addr_i] <= link_data_i;
    end
    if (ctl_i.flag_we) begin
      flag_mem[flag_addr_i] <= ctl_i.flag_data;
    end
    if (rd_en_i) begin
      link_rd_q       <= link_mem[rd_link_i];
      link_addr_q     <= rd_link_i;
      link_byp_q      <= ctl_i.link_we && (link_addr_i == rd_link_i);
      link_byp_data_q <= link_data_i;
      flag_rd_q       <= flag_mem[rd_node_i];
      node_addr_q     <= rd_node_i;
      flag_byp_q      <= ctl_i.flag_we && (flag_addr_i == rd_node_i);
      flag_byp_data_q <= ctl_i.flag_data;
    end
  end

  // Nodes below the region mark still hold their initial descending chain.
  always_comb begin
    if ((32'(link_addr_q) < 32'(region_i)) && (link_addr_q != '0)) begin
      link_o = link_addr_q - NW'(1);
    end else if (link_byp_q) begin
      link_o = link_byp_data_q;
    end else begin
      link_o = link_rd_q;
    end

    if (32'(node_addr_q) < 32'(region_i)) begin
      queued_o = 1'b1;
    end else if (flag_byp_q) begin
      queued_o = flag_byp_data_q;
    end else begin
      queued_o = flag_rd_q;
    end
  end

endmodule

[hdl/mqlbm_queue_ctrl.sv]
// ----------------------------------------------------------------------------
// Multi-queue linked buffer manager: queue control
// Per-queue head, tail and length registers, pool size and region mark, and
// the single-pass decision logic for enqueue, dequeue and length query.
// ----------------------------------------------------------------------------
`include "multi_queue_linked_buffer_manager_defines.svh"

module mqlbm_queue_ctrl #(
  parameter int unsigned NUM_QUEUES = mqlbm_pkg::NumQueuesDefault,
  parameter int unsigned POOL_DEPTH = mqlbm_pkg::PoolDepthDefault,
  localparam int unsigned NW = $clog2(POOL_DEPTH),
  localparam int unsigned QW = $clog2(NUM_QUEUES),
  localparam int unsigned CountW = mqlbm_pkg::CountW,
  localparam int unsigned QueueIdW = mqlbm_pkg::QueueIdW
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CountW-1:0]    cfg_data_i,
  input  logic                 s1_valid_i,
  input  mqlbm_pkg::req_t      s1_req_i,
  input  logic [QueueIdW-1:0]  in_queue_i,
  input  logic [NW-1:0]        link_i,
  input  logic                 queued_i,
  output logic [CountW-1:0]    region_o,
  output logic [NW-1:0]        fwd_oldest_o,
  output mqlbm_pkg::mem_ctl_t  ctl_o,
  output logic [NW-1:0]        link_addr_o,
  output logic [NW-1:0]        link_data_o,
  output logic [NW-1:0]        flag_addr_o,
  output mqlbm_pkg::rsp_t      rsp_o
);

  localparam int unsigned NodeW = mqlbm_pkg::NodeW;
  localparam logic [CountW-1:0] PoolReset =
    (POOL_DEPTH < 256) ? CountW'(POOL_DEPTH) : mqlbm_pkg::PoolSizeReset;
  localparam logic [CountW-1:0] PoolMax =
    (POOL_DEPTH > 511) ? {CountW{1'b1}} : CountW'(POOL_DEPTH);

  logic [CountW-1:0] pool_q;
  logic [CountW-1:0] region_q;
  logic [CountW-1:0] region_d;
  logic [NW-1:0]     oldest_q [NUM_QUEUES];
  logic [NW-1:0]     oldest_d [NUM_QUEUES];
  logic [NW-1:0]     newest_q [NUM_QUEUES];
  logic [NW-1:0]     newest_d [NUM_QUEUES];
  logic [CountW-1:0] length_q [NUM_QUEUES];
  logic [CountW-1:0] length_d [NUM_QUEUES];

  logic [CountW-1:0] cfg_pool;
  logic [QW-1:0]     qi;
  logic              q_ok;
  logic [NW-1:0]     node;
  logic              in_pool;
  logic [CountW-1:0] cur_len;
  logic [NW-1:0]     head;

  always_comb begin
    if (cfg_data_i == '0) begin
      cfg_pool = CountW'(1);
    end else if (cfg_data_i > PoolMax) begin
      cfg_pool = PoolMax;
    end else begin
      cfg_pool = cfg_data_i;
    end
  end

  assign qi      = QW'(s1_req_i.queue_sel);
  assign q_ok    = 32'(s1_req_i.queue_sel) < NUM_QUEUES;
  assign node    = NW'(s1_req_i.node_index);
  assign in_pool = {1'b0, s1_req_i.node_index} < pool_q;
  assign cur_len = length_q[qi];
  assign head    = oldest_q[qi];

  always_comb begin
    oldest_d    = oldest_q;
    newest_d    = newest_q;
    length_d    = length_q;
    region_d    = region_q;
    ctl_o       = '0;
    link_addr_o = '0;
    link_data_o = '0;
    flag_addr_o = '0;
    rsp_o       = '0;
    if (s1_valid_i) begin
      if (!q_ok) begin
        rsp_o.status = mqlbm_pkg::ST_EMPTY;
      end else begin
        case (s1_req_i.action)
          mqlbm_pkg::ACT_ENQUEUE: begin
            if (!in_pool) begin
              rsp_o.status = mqlbm_pkg::ST_OUTSIDE;
            end else if (queued_i) begin
              rsp_o.status = mqlbm_pkg::ST_QUEUED;
            end else begin
              if (cur_len == '0) begin
                oldest_d[qi] = node;
              end else begin
                ctl_o.link_we = 1'b1;
                link_addr_o   = newest_q[qi];
                link_data_o   = node;
              end
              newest_d[qi]    = node;
              ctl_o.flag_we   = 1'b1;
              ctl_o.flag_data = 1'b1;
              flag_addr_o     = node;
              length_d[qi]    = cur_len + CountW'(1);
            end
            rsp_o.queue_count = length_d[qi];
          end
          mqlbm_pkg::ACT_DEQUEUE: begin
            if (cur_len == '0) begin
              rsp_o.status = mqlbm_pkg::ST_EMPTY;
            end else begin
              rsp_o.node_out    = NodeW'(head);
              oldest_d[qi]      = link_i;
              ctl_o.flag_we     = 1'b1;
              flag_addr_o       = head;
              length_d[qi]      = cur_len - CountW'(1);
              rsp_o.queue_count = cur_len - CountW'(1);
              if (32'(head) < 32'(region_q)) begin
                region_d = region_q - CountW'(1);
              end
            end
          end
          default: begin
            rsp_o.queue_count = cur_len;
          end
        endcase
      end
    end
  end

  assign fwd_oldest_o = oldest_d[QW'(in_queue_i)];
  assign region_o     = region_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_q   <= PoolReset;
      region_q <= PoolReset;
      for (int i = 0; i < NUM_QUEUES; i++) begin
        oldest_q[i] <= '0;
        newest_q[i] <= '0;
        length_q[i] <= '0;
      end
      oldest_q[0] <= NW'(PoolReset - CountW'(1));
      length_q[0] <= PoolReset;
    end else if (cfg_we_i) begin
      pool_q   <= cfg_pool;
      region_q <= cfg_pool;
      for (int i = 0; i < NUM_QUEUES; i++) begin
        oldest_q[i] <= '0;
        newest_q[i] <= '0;
        length_q[i] <= '0;
      end
      oldest_q[0] <= NW'(cfg_pool - CountW'(1));
      length_q[0] <= cfg_pool;
    end else begin
      pool_q   <= pool_q;
      region_q <= region_d;
      oldest_q <= oldest_d;
      newest_q <= newest_d;
      length_q <= length_d;
    end
  end

  `MQLBM_ASSERT_IMPL(a_region_in_free, 1'b1, region_q <= length_q[0],
                     "Untouched region exceeds the free queue length.")
  `MQLBM_ASSERT_IMPL(a_region_in_pool, 1'b1, region_q <= pool_q,
                     "Untouched region exceeds the pool size.")
  `MQLBM_ASSERT_NEXT(a_cfg_rebuild, cfg_we_i, length_q[0] == pool_q,
                     "Free queue not rebuilt after a pool size write.")

endmodule
